/* rtl/vri_pkg.sv */
`timescale 1ns / 1ps

package vri_pkg;

  localparam int NAMETABLE_DEPTH = 4096;
  localparam int PATTERN_DEPTH   = 8192;
  localparam int SPRITE_DEPTH    = 256;
  localparam int PALETTE_DEPTH   = 32;

  localparam int NT_AW  = $clog2(NAMETABLE_DEPTH);
  localparam int PAT_AW = $clog2(PATTERN_DEPTH);
  localparam int SPR_AW = $clog2(SPRITE_DEPTH);
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  localparam logic [2:0] MIR_HORZ = 3'd0;
  localparam logic [2:0] MIR_VERT = 3'd1;
  localparam logic [2:0] MIR_LOW  = 3'd2;
  localparam logic [2:0] MIR_HIGH = 3'd3;

  localparam logic [5:0] PAL_PAGE = 6'h3F;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_VBLANK    = 2'd2,
    OP_PRERENDER = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_t;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_STATUS,
    SEL_OAM,
    SEL_BUF,
    SEL_PAL
  } sel_t;

  typedef struct packed {
    logic              en;
    logic [PAT_AW-1:0] idx;
  } clr_t;

  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [13:0] addr;
    logic [7:0]  wdata;
  } vmem_req_t;

  typedef struct packed {
    logic [7:0] pat;
    logic [7:0] nt;
    logic [5:0] pal;
  } vmem_rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SPR_AW-1:0] addr;
    logic [7:0]        wdata;
  } oam_req_t;

endpackage

/* rtl/vri_oam.sv */
`timescale 1ns / 1ps

module vri_oam
  import vri_pkg::*;
(
  input  logic       clk,
  input  oam_req_t   req,
  input  clr_t       clr,
  output logic [7:0] rdata
);

  logic [7:0] mem [SPRITE_DEPTH];

  always_ff @(posedge clk) begin
    if (clr.en) begin
      mem[clr.idx[SPR_AW-1:0]] <= 8'd0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

/* rtl/vri_vmem.sv */
`timescale 1ns / 1ps

module vri_vmem
  import vri_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] mirror,
  input  vmem_req_t  req,
  input  clr_t       clr,
  output vmem_rsp_t  rsp
);

  logic [7:0] pat_mem [PATTERN_DEPTH];
  logic [7:0] nt_mem  [NAMETABLE_DEPTH];
  logic [5:0] pal_mem [PALETTE_DEPTH];

  logic [PAT_AW-1:0] pat_idx;
  logic [1:0]        tab;
  logic [11:0]       nt_full;
  logic [NT_AW-1:0]  nt_idx;
  logic [PAL_AW-1:0] pal_idx;
  logic              pat_hit;
  logic              pal_hit;
  logic [7:0]        pat_q;
  logic [7:0]        nt_q;
  logic [5:0]        pal_q;

  always_comb begin
    pat_idx = req.addr[PAT_AW-1:0];
    pat_hit = !req.addr[13];
    pal_hit = (req.addr[13:8] == PAL_PAGE);
    case (mirror)
      MIR_HORZ: tab = {1'b0, req.addr[11]};
      MIR_VERT: tab = {1'b0, req.addr[10]};
      MIR_LOW:  tab = 2'd0;
      MIR_HIGH: tab = 2'd1;
      default:  tab = req.addr[11:10];
    endcase
    nt_full = {tab, req.addr[9:0]};
    nt_idx  = nt_full[NT_AW-1:0];
    pal_idx = req.addr[PAL_AW-1:0];
    // mirrors of the backdrop entries
    if (pal_idx[4] && (pal_idx[1:0] == 2'd0)) begin
      pal_idx[4] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr.en) begin
      pat_mem[clr.idx] <= 8'd0;
    end else if (req.wr_en && pat_hit) begin
      pat_mem[pat_idx] <= req.wdata;
    end
    if (req.rd_en) begin
      pat_q <= pat_mem[pat_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (clr.en) begin
      nt_mem[clr.idx[NT_AW-1:0]] <= 8'd0;
    end else if (req.wr_en && !pat_hit && !pal_hit) begin
      nt_mem[nt_idx] <= req.wdata;
    end
    if (req.rd_en) begin
      nt_q <= nt_mem[nt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (clr.en) begin
      pal_mem[clr.idx[PAL_AW-1:0]] <= 6'd0;
    end else if (req.wr_en && pal_hit) begin
      pal_mem[pal_idx] <= req.wdata[5:0];
    end
    if (req.rd_en) begin
      pal_q <= pal_mem[pal_idx];
    end
  end

  assign rsp = '{pat: pat_q, nt: nt_q, pal: pal_q};

endmodule

/* rtl/video_register_interface.sv */
`timescale 1ns / 1ps

// video register interface: cpu register window plus timing events
// s channel: one request per cpu access or event, op in s_tuser, register
//   number and write byte in s_tdata
// m channel: one result per request with read byte, nmi level, v, fine x,
//   control and mask as they stand after the request
// cfg channel: writes the nametable mirror mode, always ready; write only
//   while the block is idle
// pipeline: an accepted request is registered into the memory stage and then
//   into the output register, which drives m_tvalid; the memories are read at
//   the accept edge and the read byte and data buffer are resolved in the
//   following cycle
// throughput: one request per cycle when not clearing or stalled; register
//   updates land at the accept edge, so each request sees the prior one's state
// reset: a clearing pass writes zero to pattern, nametable, palette and
//   sprite memories, one entry a cycle until all PATTERN_DEPTH (8192) entries
//   are done; s_tready stays low until it ends
// stall: while m_tready is low the output register holds its result, one
//   more request waits in the memory stage, then s_tready drops

module video_register_interface
  import vri_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // reg_addr[2:0], write_data[10:3], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // read_data[7:0], nmi_line[8], scroll_addr[24:9],
                                 // fine_scroll_x[27:25], control_value[35:28],
                                 // mask_value[43:36], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  op_t        op;
  reg_t       rnum;
  logic [7:0] wd;
  logic       s_acc;

  logic [2:0]  mirror;
  logic [7:0]  control, control_next;
  logic [7:0]  mask, mask_next;
  logic        vblank, vblank_next;
  logic [7:0]  spr_addr, spr_addr_next;
  logic [14:0] t_addr, t_addr_next;
  logic [15:0] v_addr, v_addr_next;
  logic        toggle, toggle_next;
  logic [2:0]  fine_x, fine_x_next;
  logic        nmi, nmi_next;
  logic [15:0] v_inc;
  sel_t        sel_next;
  logic        pat_next;

  logic              clearing;
  logic [PAT_AW-1:0] clr_cnt;
  clr_t              clr;

  oam_req_t   oam_req;
  logic [7:0] oam_q;
  vmem_req_t  vreq;
  vmem_rsp_t  vrsp;

  logic        pv;
  sel_t        p_sel;
  logic        p_pat;
  logic        p_vbl;
  logic        p_nmi;
  logic [15:0] p_v;
  logic [2:0]  p_fx;
  logic [7:0]  p_ctrl;
  logic [7:0]  p_mask;
  logic        p_move;

  logic [7:0] rbuf, rbuf_next;
  logic [7:0] rd;

  logic        ov;
  logic [7:0]  o_rd;
  logic        o_nmi;
  logic [15:0] o_v;
  logic [2:0]  o_fx;
  logic [7:0]  o_ctrl;
  logic [7:0]  o_mask;

  assign op    = op_t'(s_tuser);
  assign rnum  = reg_t'(s_tdata[2:0]);
  assign wd    = s_tdata[10:3];
  assign s_acc = s_tvalid && s_tready;

  assign p_move   = pv && (!ov || m_tready);
  assign s_tready = !clearing && (!pv || p_move);
  assign cfg_ready = 1'b1;

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == {PAT_AW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  assign clr = '{en: clearing, idx: clr_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror <= MIR_HORZ;
    end else if (cfg_valid && cfg_ready) begin
      mirror <= cfg_data;
    end
  end

  // register side, resolved at the accept edge
  always_comb begin
    control_next  = control;
    mask_next     = mask;
    vblank_next   = vblank;
    spr_addr_next = spr_addr;
    t_addr_next   = t_addr;
    v_addr_next   = v_addr;
    toggle_next   = toggle;
    fine_x_next   = fine_x;
    nmi_next      = nmi;
    sel_next      = SEL_NONE;
    pat_next      = !v_addr[13];
    v_inc         = control[2] ? 16'd32 : 16'd1;
    oam_req       = '{rd_en: 1'b0, wr_en: 1'b0, addr: spr_addr, wdata: wd};
    vreq          = '{rd_en: 1'b0, wr_en: 1'b0, addr: v_addr[13:0], wdata: wd};
    case (op)
      OP_READ: begin
        case (rnum)
          REG_STATUS: begin
            sel_next    = SEL_STATUS;
            vblank_next = 1'b0;
            toggle_next = 1'b0;
          end
          REG_OAM_DATA: begin
            sel_next      = SEL_OAM;
            oam_req.rd_en = 1'b1;
          end
          REG_DATA: begin
            sel_next    = (v_addr[13:8] == PAL_PAGE) ? SEL_PAL : SEL_BUF;
            vreq.rd_en  = 1'b1;
            v_addr_next = v_addr + v_inc;
          end
          default: begin
            sel_next = SEL_NONE;
          end
        endcase
      end
      OP_WRITE: begin
        case (rnum)
          REG_CTRL: begin
            control_next       = wd;
            t_addr_next[11:10] = wd[1:0];
          end
          REG_MASK: begin
            mask_next = wd;
          end
          REG_OAM_ADDR: begin
            spr_addr_next = wd;
          end
          REG_OAM_DATA: begin
            oam_req.wr_en = 1'b1;
            spr_addr_next = spr_addr + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle) begin
              t_addr_next[4:0] = wd[7:3];
              fine_x_next      = wd[2:0];
            end else begin
              t_addr_next[9:5]   = wd[7:3];
              t_addr_next[14:12] = wd[2:0];
            end
            toggle_next = !toggle;
          end
          REG_ADDR: begin
            if (!toggle) begin
              t_addr_next[13:8] = wd[5:0];
              t_addr_next[14]   = 1'b0;
            end else begin
              t_addr_next[7:0] = wd;
              v_addr_next      = {1'b0, t_addr[14:8], wd};
            end
            toggle_next = !toggle;
          end
          REG_DATA: begin
            vreq.wr_en  = 1'b1;
            v_addr_next = v_addr + v_inc;
          end
          default: begin
            sel_next = SEL_NONE;
          end
        endcase
      end
      OP_VBLANK: begin
        vblank_next = 1'b1;
        if (control[7]) begin
          nmi_next = 1'b1;
        end
      end
      OP_PRERENDER: begin
        vblank_next = 1'b0;
        nmi_next    = 1'b0;
      end
      default: begin
        sel_next = SEL_NONE;
      end
    endcase
    if (!s_acc) begin
      oam_req.rd_en = 1'b0;
      oam_req.wr_en = 1'b0;
      vreq.rd_en    = 1'b0;
      vreq.wr_en    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control  <= '0;
      mask     <= '0;
      vblank   <= 1'b0;
      spr_addr <= '0;
      t_addr   <= '0;
      v_addr   <= '0;
      toggle   <= 1'b0;
      fine_x   <= '0;
      nmi      <= 1'b0;
    end else if (s_acc) begin
      control  <= control_next;
      mask     <= mask_next;
      vblank   <= vblank_next;
      spr_addr <= spr_addr_next;
      t_addr   <= t_addr_next;
      v_addr   <= v_addr_next;
      toggle   <= toggle_next;
      fine_x   <= fine_x_next;
      nmi      <= nmi_next;
    end
  end

  vri_oam u_oam (
    .clk   (clk),
    .req   (oam_req),
    .clr   (clr),
    .rdata (oam_q)
  );

  vri_vmem u_vmem (
    .clk    (clk),
    .mirror (mirror),
    .req    (vreq),
    .clr    (clr),
    .rsp    (vrsp)
  );

  // memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (s_acc) begin
      pv <= 1'b1;
    end else if (p_move) begin
      pv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      p_sel  <= sel_next;
      p_pat  <= pat_next;
      p_vbl  <= vblank;
      p_nmi  <= nmi_next;
      p_v    <= v_addr_next;
      p_fx   <= fine_x_next;
      p_ctrl <= control_next;
      p_mask <= mask_next;
    end
  end

  always_comb begin
    rd        = 8'd0;
    rbuf_next = rbuf;
    case (p_sel)
      SEL_STATUS: begin
        rd = {p_vbl, 7'd0};
      end
      SEL_OAM: begin
        rd = oam_q;
      end
      SEL_BUF: begin
        rd        = rbuf;
        rbuf_next = p_pat ? vrsp.pat : vrsp.nt;
      end
      SEL_PAL: begin
        rd        = {2'd0, vrsp.pal};
        rbuf_next = vrsp.nt;
      end
      default: begin
        rd = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rbuf <= '0;
    end else if (p_move) begin
      rbuf <= rbuf_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (p_move) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_rd   <= rd;
      o_nmi  <= p_nmi;
      o_v    <= p_v;
      o_fx   <= p_fx;
      o_ctrl <= p_ctrl;
      o_mask <= p_mask;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {4'd0, o_mask, o_ctrl, o_fx, o_v, o_nmi, o_rd};

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("request taken during clearing pass");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> pv)
    else $error("accepted request missing from memory stage");

  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (op == OP_READ) && (rnum == REG_STATUS)) |=> !vblank)
    else $error("status read did not clear vblank");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> (mirror == $past(cfg_data)))
    else $error("mirror mode not written");
`endif

endmodule
